// ===== src/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console cursor writer: command and
// result codes, transfer payloads and the queue entry between front and back.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // screen geometry defaults
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // result field widths
    localparam int CELL_W = 11;
    localparam int SROW_W = 5;
    localparam int SCOL_W = 7;

    // command codes
    localparam logic [1:0] CMD_PUT_CHAR = 2'd0;
    localparam logic [1:0] CMD_HEX2     = 2'd1;
    localparam logic [1:0] CMD_HEX8     = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    // result operation codes
    localparam logic [1:0] OP_WRITE        = 2'd0;
    localparam logic [1:0] OP_CLEAR_ROW    = 2'd1;
    localparam logic [1:0] OP_CLEAR_SCREEN = 2'd2;

    // character constants
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_A       = 8'h41;

    // attribute register reset value
    localparam logic [7:0] ATTR_RESET = 8'h02;

    // classified command kind
    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_HEX2,
        KIND_HEX8,
        KIND_CLEAR
    } t_kind;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        op;
        logic [CELL_W-1:0] cell_index;
        logic [SROW_W-1:0] screen_row;
        logic [SCOL_W-1:0] screen_col;
        logic [7:0]        char_code;
        logic [7:0]        attr_byte;
        logic              last;
    } t_out_item;

    // queue entry: kind, first hex digit to print, value
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  first_digit;
        logic [31:0] value;
    } t_entry;

    // uppercase hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CHAR_ZERO + {4'd0, nib};
        end else begin
            ch = CHAR_A + {4'd0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// ===== src/tccw_front.sv =====
// ----------------------------------------------------------------------------
// tccw_front
// Accepts commands, classifies them into kinds with their first hex digit,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tccw_front import tccw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_head_valid,
    output t_entry   o_head,
    input  logic     i_pop
);

    t_entry     r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_entry     w_entry;
    logic       w_push;

    // classify the incoming command
    always_comb begin
        w_entry.value = i_in_data.value;
        unique case (i_in_data.cmd)
            CMD_PUT_CHAR: begin
                w_entry.kind        = KIND_CHAR;
                w_entry.first_digit = 3'd0;
            end
            CMD_HEX2: begin
                w_entry.kind        = KIND_HEX2;
                w_entry.first_digit = 3'd1;
                w_entry.value       = {24'd0, i_in_data.value[7:0]};
            end
            CMD_HEX8: begin
                w_entry.kind        = KIND_HEX8;
                w_entry.first_digit = 3'd7;
            end
            default: begin
                w_entry.kind        = KIND_CLEAR;
                w_entry.first_digit = 3'd0;
            end
        endcase
    end

    assign o_in_stall   = (r_count == 2'd2);
    assign w_push       = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];

    // queue pointers and fill count
    always_comb begin
        n_wr_ptr = w_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, w_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

endmodule

// ===== src/tccw_back.sv =====
// ----------------------------------------------------------------------------
// tccw_back
// Sequencer that expands the queue head into screen-update results, one per
// cycle while the output is not stalled, keeps the cursor and the attribute
// register, and drives the output register.
// ----------------------------------------------------------------------------
module tccw_back import tccw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic      i_head_valid,
    input  t_entry    i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int COL_W = $clog2(COLUMNS + 1);
    localparam int ROW_W = $clog2(ROWS);
    localparam int IDX_W = $clog2(ROWS * COLUMNS) + 1;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [2:0]       r_digit, n_digit;
    logic             r_started, n_started;
    logic [7:0]       r_attr;
    logic             r_out_valid;
    t_out_item        r_out, n_out;

    logic             w_adv;
    logic             w_done;
    logic [2:0]       w_cur_digit;
    logic [31:0]      w_shifted;
    logic [7:0]       w_ch;
    logic [ROW_W-1:0] w_row_next;
    logic [IDX_W-1:0] w_idx_write;
    logic [IDX_W-1:0] w_idx_next_row;

    assign w_adv = i_head_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = w_adv && w_done;

    // current character of the head item
    assign w_cur_digit = r_started ? r_digit : i_head.first_digit;
    assign w_shifted   = i_head.value >> {w_cur_digit, 2'b00};
    assign w_ch        = (i_head.kind == KIND_CHAR) ? i_head.value[7:0]
                                                    : hex_char(w_shifted[3:0]);

    // next row with wrap, and cell indices
    assign w_row_next     = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + 1'b1;
    assign w_idx_write    = IDX_W'(r_row) * IDX_W'(COLUMNS) + IDX_W'(r_col);
    assign w_idx_next_row = IDX_W'(w_row_next) * IDX_W'(COLUMNS);

    // result and cursor update for the head item
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_digit   = r_digit;
        n_started = r_started;
        n_out     = '0;
        w_done    = 1'b0;
        priority if (i_head.kind == KIND_CLEAR) begin
            n_out.op   = OP_CLEAR_SCREEN;
            n_out.last = 1'b1;
            n_row      = '0;
            n_col      = '0;
            n_started  = 1'b0;
            w_done     = 1'b1;
        end else if (i_head.kind == KIND_CHAR && w_ch == CHAR_NEWLINE) begin
            n_out.op         = OP_CLEAR_ROW;
            n_out.cell_index = CELL_W'(w_idx_next_row);
            n_out.screen_row = SROW_W'(w_row_next);
            n_out.last       = 1'b1;
            n_row            = w_row_next;
            n_col            = '0;
            n_started        = 1'b0;
            w_done           = 1'b1;
        end else if (r_col >= COL_W'(COLUMNS)) begin
            // full row: wrap and clear before writing
            n_out.op         = OP_CLEAR_ROW;
            n_out.cell_index = CELL_W'(w_idx_next_row);
            n_out.screen_row = SROW_W'(w_row_next);
            n_row            = w_row_next;
            n_col            = '0;
            n_digit          = w_cur_digit;
            n_started        = 1'b1;
        end else begin
            n_out.op         = OP_WRITE;
            n_out.cell_index = CELL_W'(w_idx_write);
            n_out.screen_row = SROW_W'(r_row);
            n_out.screen_col = SCOL_W'(r_col);
            n_out.char_code  = w_ch;
            n_out.attr_byte  = r_attr;
            n_out.last       = (w_cur_digit == 3'd0);
            n_col            = r_col + 1'b1;
            if (w_cur_digit == 3'd0) begin
                n_started = 1'b0;
                w_done    = 1'b1;
            end else begin
                n_digit   = w_cur_digit - 3'd1;
                n_started = 1'b1;
            end
        end
    end

    // cursor and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_digit   <= 3'd0;
            r_started <= 1'b0;
        end else if (w_adv) begin
            r_row     <= n_row;
            r_col     <= n_col;
            r_digit   <= n_digit;
            r_started <= n_started;
        end
    end

    // attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/text_console_cursor_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_writer_core
// Text console cursor writer: turns character, hex and clear commands into
// write-cell, clear-row and clear-screen results over a character screen.
// ----------------------------------------------------------------------------
// A command produces one to nine results (a character or newline one, a
// wrapping character two, a hex2 two or three, a hex8 eight or nine, a clear
// one), delivered by the single back-end sequencer, which sets the throughput,
// at one result per cycle while the output is not stalled. A two-entry command
// queue sits in front of the sequencer, so commands are taken while earlier
// ones are still being expanded, and the first result of a command enters the
// output register once it is at the queue head and the output is not stalled.
// The attribute byte is written through i_cfg_wr_en; the user must do so only
// while the block is idle, which the block does not enforce; it resets to 0x02.
module text_console_cursor_writer_core import tccw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data
);

    logic   w_head_valid;
    t_entry w_head;
    logic   w_pop;

    // command intake and queue
    tccw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // result sequencer
    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head_valid  (w_head_valid),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    // a clear-screen result always ends its command
    a_clear_screen_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.op == OP_CLEAR_SCREEN |-> o_out_data.last)
        else $error("clear-screen result not marked last");

    // row clears carry no column, character or attribute
    a_clear_row_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.op == OP_CLEAR_ROW |->
        o_out_data.screen_col == '0 && o_out_data.char_code == '0 &&
        o_out_data.attr_byte == '0)
        else $error("clear-row result with nonzero fields");

    // only the three result codes appear
    a_op_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.op == OP_WRITE || o_out_data.op == OP_CLEAR_ROW ||
        o_out_data.op == OP_CLEAR_SCREEN)
        else $error("invalid result operation code");

endmodule
